// ===== hdl/tmplan_pkg.sv =====
// Shared types and constants for the trapezoidal motion planner.
// No dependencies; used by tmplan_dp, tmplan_ctrl, the top level and the bench.
package tmplan_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_QUEUE = 2'd1,
    CMD_FORCE = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ACCEL = 2'd1,
    PH_CONST = 2'd2,
    PH_DECEL = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_HOLD,
    S_DIV_A,
    S_DIV_D,
    S_DIV_C,
    S_CHECK,
    S_DIV_PK,
    S_DIV_AR,
    S_DIV_DR,
    S_INIT,
    S_VEL,
    S_POS,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_APPLY,
    OP_ECHO,
    OP_TAKE,
    OP_HOLD,
    OP_DIV_A,
    OP_DIV_D,
    OP_DIV_C,
    OP_DIV_PK,
    OP_DIV_AR,
    OP_DIV_DR,
    OP_INIT,
    OP_VEL,
    OP_POS,
    OP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   div_start;
  } dp_cmd_t;

  typedef struct packed {
    cmd_code_t cmd;
    logic      moving;
    logic      pending;
    logic      timing_bad;
    logic      ticks_zero;
    logic      div_busy;
    logic      div_done;
  } dp_stat_t;

  localparam int unsigned DIV_W  = 64;
  localparam int unsigned ADDR_W = 4;

  localparam logic [16:0] FRAC_ONE = 17'd65536;

  localparam logic [1:0] REG_TICK_PERIOD = 2'd0;
  localparam logic [1:0] REG_ACCEL_FRAC  = 2'd1;
  localparam logic [1:0] REG_DECEL_FRAC  = 2'd2;

  localparam logic [7:0]  TICK_PERIOD_RST = 8'd10;
  localparam logic [16:0] ACCEL_FRAC_RST  = 17'd16384;
  localparam logic [16:0] DECEL_FRAC_RST  = 17'd16384;

endpackage

// ===== hdl/tmplan_in_if.sv =====
// Input channel of the motion planner: valid/ready plus one item.
// Depends on nothing.
interface tmplan_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] measured_position;
  logic signed [31:0] plan_target;
  logic [15:0]        plan_duration_ms;

  modport source (output valid, command, measured_position, plan_target,
                  plan_duration_ms, input ready);
  modport sink (input valid, command, measured_position, plan_target,
                plan_duration_ms, output ready);
endinterface

// ===== hdl/tmplan_out_if.sv =====
// Result channel of the motion planner: valid/ready plus one result.
// Depends on nothing.
interface tmplan_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] setpoint;
  logic [1:0]         phase;
  logic               plan_pending;

  modport source (output valid, setpoint, phase, plan_pending, input ready);
  modport sink (input valid, setpoint, phase, plan_pending, output ready);
endinterface

// ===== hdl/tmplan_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the datapath.
module tmplan_div #(
  parameter int unsigned W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output logic         busy,
  output logic         done
);
  localparam int unsigned CW = $clog2(W);
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  den;
  logic [CW-1:0] cnt;
  logic [W:0]    rem_sh;
  logic [W:0]    trial;
  logic          ge;

  assign rem_sh   = {rem, quo[W-1]};
  assign trial    = rem_sh - {1'b0, den};
  assign ge       = !trial[W];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
        den  <= divisor;
      end else if (busy) begin
        rem <= ge ? trial[W-1:0] : rem_sh[W-1:0];
        quo <= {quo[W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hdl/tmplan_dp.sv =====
// Planner datapath: plan and motion state, shared divider, step arithmetic.
// Depends on tmplan_pkg and tmplan_div.
module tmplan_dp #(
  parameter int unsigned PFB = 16,
  parameter int unsigned DW  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tmplan_pkg::dp_cmd_t  cmd,
  output tmplan_pkg::dp_stat_t stat,
  input  logic [7:0]           tick_period_ms,
  input  logic [16:0]          accel_fraction,
  input  logic [16:0]          decel_fraction,
  input  logic [1:0]           command,
  input  logic signed [31:0]   measured_position,
  input  logic signed [31:0]   plan_target,
  input  logic [15:0]          plan_duration_ms,
  output logic signed [31:0]   setpoint,
  output logic [1:0]           phase,
  output logic                 plan_pending
);
  localparam int unsigned VW = 32 + PFB;
  localparam int unsigned HW = DW + 2;
  localparam int unsigned NW = tmplan_pkg::DIV_W;
  localparam logic [NW-1:0] VMAX_Q = (NW'(1) << (VW - 1)) - NW'(1);
  localparam logic [VW:0]   HALF   = (VW + 1)'(1) << (PFB - 1);
  localparam logic [15:0]   DUR_MASK =
    (DW >= 16) ? 16'hFFFF : 16'((32'd1 << DW) - 32'd1);

  // quotient magnitude and sign to a saturated velocity
  function automatic logic signed [VW-1:0] sat_q(logic [NW-1:0] q, logic neg);
    logic signed [VW-1:0] lo;
    lo = q[VW-1:0];
    if (!neg) begin
      return (q > VMAX_Q) ? {1'b0, {(VW-1){1'b1}}} : lo;
    end
    return (q > VMAX_Q + NW'(1)) ? {1'b1, {(VW-1){1'b0}}} : -lo;
  endfunction

  function automatic logic signed [VW-1:0] sat_add(logic signed [VW-1:0] x,
                                                  logic signed [VW-1:0] y);
    logic signed [VW:0] s;
    s = {x[VW-1], x} + {y[VW-1], y};
    if (s[VW] != s[VW-1]) begin
      return s[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end
    return s[VW-1:0];
  endfunction

  // latched item
  tmplan_pkg::cmd_code_t cur_cmd;
  logic signed [31:0]    cur_meas;
  logic signed [31:0]    cur_tgt;
  logic [15:0]           cur_dur;

  // plan and motion state
  tmplan_pkg::phase_t   mphase;
  logic                 pending;
  logic signed [31:0]   pend_tgt;
  logic [15:0]          pend_dur;
  logic [DW-1:0]        a_ticks;
  logic [DW-1:0]        c_ticks;
  logic [DW-1:0]        d_ticks;
  logic [DW-1:0]        count;
  logic signed [VW-1:0] peak;
  logic signed [VW-1:0] arate;
  logic signed [VW-1:0] drate;
  logic signed [VW-1:0] last_v;
  logic signed [31:0]   last_sp;
  logic signed [VW-1:0] vel;
  logic signed [31:0]   res_sp;

  // output register
  logic signed [31:0]   sp_q;
  tmplan_pkg::phase_t   phase_q;
  logic                 pend_q;

  // divider
  logic [NW-1:0] div_num;
  logic [NW-1:0] div_den;
  logic [NW-1:0] div_q;
  logic          div_busy;
  logic          div_done;

  // combinational helpers
  logic [16:0]          af;
  logic [16:0]          df;
  logic [17:0]          frac_sum;
  logic [17:0]          cf_wide;
  logic [16:0]          cf;
  logic [16:0]          frac_sel;
  logic [32:0]          tick_num;
  logic signed [32:0]   dpos;
  logic                 dpos_neg;
  logic [32:0]          dpos_mag;
  logic [HW-1:0]        h_sum;
  logic                 pk_neg;
  logic [VW-1:0]        pk_mag;
  logic signed [VW-1:0] v_next;
  logic [DW-1:0]        limit;
  logic [DW-1:0]        cnt_inc;
  tmplan_pkg::phase_t   phase_after;
  logic signed [VW:0]   vel_rnd;
  logic signed [VW:0]   vel_sh;
  logic signed [33:0]   sp_sum;
  logic signed [31:0]   sp_new;

  assign af       = (accel_fraction > tmplan_pkg::FRAC_ONE) ? tmplan_pkg::FRAC_ONE
                                                             : accel_fraction;
  assign df       = (decel_fraction > tmplan_pkg::FRAC_ONE) ? tmplan_pkg::FRAC_ONE
                                                             : decel_fraction;
  assign frac_sum = {1'b0, af} + {1'b0, df};
  assign cf_wide  = {1'b0, tmplan_pkg::FRAC_ONE} - frac_sum;
  assign cf       = (frac_sum >= {1'b0, tmplan_pkg::FRAC_ONE}) ? 17'd0 : cf_wide[16:0];

  assign dpos     = {pend_tgt[31], pend_tgt} - {cur_meas[31], cur_meas};
  assign dpos_neg = dpos[32];
  assign dpos_mag = dpos_neg ? 33'(-dpos) : 33'(dpos);
  assign h_sum    = HW'(a_ticks) + HW'(d_ticks) + (HW'(c_ticks) << 1);
  assign pk_neg   = peak[VW-1];
  assign pk_mag   = pk_neg ? VW'(-peak) : VW'(peak);

  always_comb begin
    case (cmd.op)
      tmplan_pkg::OP_DIV_A: frac_sel = af;
      tmplan_pkg::OP_DIV_D: frac_sel = df;
      default:              frac_sel = cf;
    endcase
  end

  assign tick_num = frac_sel * pend_dur;

  always_comb begin
    case (cmd.op)
      tmplan_pkg::OP_DIV_A, tmplan_pkg::OP_DIV_D, tmplan_pkg::OP_DIV_C: begin
        div_num = NW'(tick_num);
        div_den = NW'({tick_period_ms, 16'd0});
      end
      tmplan_pkg::OP_DIV_PK: begin
        div_num = NW'(dpos_mag) << (PFB + 1);
        div_den = NW'(h_sum);
      end
      tmplan_pkg::OP_DIV_AR: begin
        div_num = NW'(pk_mag);
        div_den = NW'(a_ticks);
      end
      tmplan_pkg::OP_DIV_DR: begin
        div_num = NW'(pk_mag);
        div_den = NW'(d_ticks);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  tmplan_div #(.W(NW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .quotient (div_q),
    .busy     (div_busy),
    .done     (div_done)
  );

  // one motion step: velocity and phase counter
  always_comb begin
    case (mphase)
      tmplan_pkg::PH_ACCEL: begin
        v_next      = sat_add(last_v, arate);
        limit       = a_ticks;
        phase_after = tmplan_pkg::PH_CONST;
      end
      tmplan_pkg::PH_CONST: begin
        v_next      = peak;
        limit       = c_ticks;
        phase_after = tmplan_pkg::PH_DECEL;
      end
      tmplan_pkg::PH_DECEL: begin
        v_next      = sat_add(last_v, drate);
        limit       = d_ticks;
        phase_after = tmplan_pkg::PH_IDLE;
      end
      default: begin
        v_next      = last_v;
        limit       = '0;
        phase_after = tmplan_pkg::PH_IDLE;
      end
    endcase
  end

  assign cnt_inc = count + 1'b1;

  // position update: round half up, add, saturate
  assign vel_rnd = {vel[VW-1], vel} + HALF;
  assign vel_sh  = vel_rnd >>> PFB;
  assign sp_sum  = {{2{last_sp[31]}}, last_sp} + {vel_sh[32], vel_sh[32:0]};

  always_comb begin
    if (sp_sum[33:31] == 3'b000 || sp_sum[33:31] == 3'b111) begin
      sp_new = sp_sum[31:0];
    end else begin
      sp_new = sp_sum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mphase  <= tmplan_pkg::PH_IDLE;
      pending <= 1'b0;
      last_sp <= '0;
    end else begin
      case (cmd.op)
        tmplan_pkg::OP_LATCH: begin
          cur_cmd  <= tmplan_pkg::cmd_code_t'(command);
          cur_meas <= measured_position;
          cur_tgt  <= plan_target;
          cur_dur  <= plan_duration_ms;
        end
        tmplan_pkg::OP_APPLY: begin
          res_sp <= last_sp;
          case (cur_cmd)
            tmplan_pkg::CMD_QUEUE, tmplan_pkg::CMD_FORCE: begin
              pend_tgt <= cur_tgt;
              pend_dur <= cur_dur & DUR_MASK;
              pending  <= 1'b1;
              if (cur_cmd == tmplan_pkg::CMD_FORCE) begin
                mphase <= tmplan_pkg::PH_IDLE;
              end
            end
            default: begin
              mphase  <= tmplan_pkg::PH_IDLE;
              pending <= 1'b0;
            end
          endcase
        end
        tmplan_pkg::OP_ECHO: res_sp <= cur_meas;
        tmplan_pkg::OP_TAKE: pending <= 1'b0;
        tmplan_pkg::OP_HOLD: res_sp <= last_sp;
        tmplan_pkg::OP_INIT: begin
          last_v  <= '0;
          last_sp <= cur_meas;
          count   <= '0;
          mphase  <= tmplan_pkg::PH_ACCEL;
        end
        tmplan_pkg::OP_VEL: begin
          vel    <= v_next;
          last_v <= v_next;
          if (cnt_inc >= limit) begin
            mphase <= phase_after;
            count  <= '0;
          end else begin
            count <= cnt_inc;
          end
        end
        tmplan_pkg::OP_POS: begin
          last_sp <= sp_new;
          res_sp  <= sp_new;
        end
        tmplan_pkg::OP_LOAD_OUT: begin
          sp_q    <= res_sp;
          phase_q <= mphase;
          pend_q  <= pending;
        end
        default: ;
      endcase
      if (div_done) begin
        case (cmd.op)
          tmplan_pkg::OP_DIV_A:  a_ticks <= div_q[DW-1:0];
          tmplan_pkg::OP_DIV_D:  d_ticks <= div_q[DW-1:0];
          tmplan_pkg::OP_DIV_C:  c_ticks <= div_q[DW-1:0];
          tmplan_pkg::OP_DIV_PK: peak    <= sat_q(div_q, dpos_neg);
          tmplan_pkg::OP_DIV_AR: arate   <= sat_q(div_q, pk_neg);
          tmplan_pkg::OP_DIV_DR: drate   <= sat_q(div_q, !pk_neg);
          default: ;
        endcase
      end
    end
  end

  assign stat.cmd        = cur_cmd;
  assign stat.moving     = (mphase != tmplan_pkg::PH_IDLE);
  assign stat.pending    = pending;
  assign stat.timing_bad = (tick_period_ms == 8'd0) ||
                           (pend_dur <= {8'd0, tick_period_ms});
  assign stat.ticks_zero = (a_ticks == '0) || (d_ticks == '0);
  assign stat.div_busy   = div_busy;
  assign stat.div_done   = div_done;

  assign setpoint     = sp_q;
  assign phase        = phase_q;
  assign plan_pending = pend_q;
endmodule

// ===== hdl/tmplan_ctrl.sv =====
// Planner sequencer: walks each item through the datapath operations.
// Depends on tmplan_pkg.
module tmplan_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  tmplan_pkg::dp_stat_t stat,
  output tmplan_pkg::dp_cmd_t  cmd
);
  tmplan_pkg::state_t state;
  tmplan_pkg::state_t state_next;
  logic               load_out;
  logic               div_ok;

  assign in_ready = (state == tmplan_pkg::S_IDLE);
  assign load_out = (state == tmplan_pkg::S_DONE) && (!out_valid || out_ready);
  assign div_ok   = stat.div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tmplan_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tmplan_pkg::S_IDLE:
        if (in_valid) state_next = tmplan_pkg::S_DISPATCH;
      tmplan_pkg::S_DISPATCH: begin
        if (stat.cmd != tmplan_pkg::CMD_TICK) begin
          state_next = tmplan_pkg::S_DONE;
        end else if (stat.moving) begin
          state_next = tmplan_pkg::S_VEL;
        end else if (!stat.pending) begin
          state_next = tmplan_pkg::S_DONE;
        end else if (stat.timing_bad) begin
          state_next = tmplan_pkg::S_HOLD;
        end else begin
          state_next = tmplan_pkg::S_DIV_A;
        end
      end
      tmplan_pkg::S_HOLD:   state_next = tmplan_pkg::S_DONE;
      tmplan_pkg::S_DIV_A:  if (div_ok) state_next = tmplan_pkg::S_DIV_D;
      tmplan_pkg::S_DIV_D:  if (div_ok) state_next = tmplan_pkg::S_DIV_C;
      tmplan_pkg::S_DIV_C:  if (div_ok) state_next = tmplan_pkg::S_CHECK;
      tmplan_pkg::S_CHECK:
        state_next = stat.ticks_zero ? tmplan_pkg::S_HOLD : tmplan_pkg::S_DIV_PK;
      tmplan_pkg::S_DIV_PK: if (div_ok) state_next = tmplan_pkg::S_DIV_AR;
      tmplan_pkg::S_DIV_AR: if (div_ok) state_next = tmplan_pkg::S_DIV_DR;
      tmplan_pkg::S_DIV_DR: if (div_ok) state_next = tmplan_pkg::S_INIT;
      tmplan_pkg::S_INIT:   state_next = tmplan_pkg::S_VEL;
      tmplan_pkg::S_VEL:    state_next = tmplan_pkg::S_POS;
      tmplan_pkg::S_POS:    state_next = tmplan_pkg::S_DONE;
      tmplan_pkg::S_DONE:   if (load_out) state_next = tmplan_pkg::S_IDLE;
      default:              state_next = tmplan_pkg::S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.op        = tmplan_pkg::OP_NONE;
    cmd.div_start = 1'b0;
    case (state)
      tmplan_pkg::S_IDLE:
        if (in_valid) cmd.op = tmplan_pkg::OP_LATCH;
      tmplan_pkg::S_DISPATCH: begin
        if (stat.cmd != tmplan_pkg::CMD_TICK) begin
          cmd.op = tmplan_pkg::OP_APPLY;
        end else if (stat.moving) begin
          cmd.op = tmplan_pkg::OP_NONE;
        end else if (!stat.pending) begin
          cmd.op = tmplan_pkg::OP_ECHO;
        end else begin
          cmd.op = tmplan_pkg::OP_TAKE;
        end
      end
      tmplan_pkg::S_HOLD:   cmd.op = tmplan_pkg::OP_HOLD;
      tmplan_pkg::S_DIV_A:  cmd.op = tmplan_pkg::OP_DIV_A;
      tmplan_pkg::S_DIV_D:  cmd.op = tmplan_pkg::OP_DIV_D;
      tmplan_pkg::S_DIV_C:  cmd.op = tmplan_pkg::OP_DIV_C;
      tmplan_pkg::S_DIV_PK: cmd.op = tmplan_pkg::OP_DIV_PK;
      tmplan_pkg::S_DIV_AR: cmd.op = tmplan_pkg::OP_DIV_AR;
      tmplan_pkg::S_DIV_DR: cmd.op = tmplan_pkg::OP_DIV_DR;
      tmplan_pkg::S_INIT:   cmd.op = tmplan_pkg::OP_INIT;
      tmplan_pkg::S_VEL:    cmd.op = tmplan_pkg::OP_VEL;
      tmplan_pkg::S_POS:    cmd.op = tmplan_pkg::OP_POS;
      tmplan_pkg::S_DONE:
        if (load_out) cmd.op = tmplan_pkg::OP_LOAD_OUT;
      default: ;
    endcase
    if ((state == tmplan_pkg::S_DIV_A  || state == tmplan_pkg::S_DIV_D ||
         state == tmplan_pkg::S_DIV_C  || state == tmplan_pkg::S_DIV_PK ||
         state == tmplan_pkg::S_DIV_AR || state == tmplan_pkg::S_DIV_DR) &&
        !stat.div_busy && !stat.div_done) begin
      cmd.div_start = 1'b1;
    end
  end
endmodule

// ===== hdl/trapezoidal_motion_planner.sv =====
// Trapezoidal motion planner, top level: APB registers, sequencer, datapath.
// A tick that starts a plan runs six passes of the shared divider.
// One item at a time; next item taken once the result sits in the output register.
// Reset (rst, sync, active high): idle, no plan, last setpoint 0, registers to defaults.
// Depends on tmplan_pkg, tmplan_in_if, tmplan_out_if, tmplan_ctrl, tmplan_dp.
module trapezoidal_motion_planner #(
  parameter int unsigned POSITION_FRAC_BITS = 16,
  parameter int unsigned DURATION_BITS      = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  tmplan_in_if.sink                     item,
  tmplan_out_if.source                  result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tmplan_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  // configuration registers
  logic [7:0]  tick_period_ms;
  logic [16:0] accel_fraction;
  logic [16:0] decel_fraction;
  logic        wr_en;
  logic [1:0]  reg_idx;

  tmplan_pkg::dp_cmd_t  dp_cmd;
  tmplan_pkg::dp_stat_t dp_stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  // write lands on the access beat of the APB transfer
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period_ms <= tmplan_pkg::TICK_PERIOD_RST;
      accel_fraction <= tmplan_pkg::ACCEL_FRAC_RST;
      decel_fraction <= tmplan_pkg::DECEL_FRAC_RST;
    end else if (wr_en) begin
      case (reg_idx)
        tmplan_pkg::REG_TICK_PERIOD: tick_period_ms <= pwdata[7:0];
        tmplan_pkg::REG_ACCEL_FRAC:  accel_fraction <= pwdata[16:0];
        tmplan_pkg::REG_DECEL_FRAC:  decel_fraction <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tmplan_pkg::REG_TICK_PERIOD: prdata = {24'd0, tick_period_ms};
      tmplan_pkg::REG_ACCEL_FRAC:  prdata = {15'd0, accel_fraction};
      tmplan_pkg::REG_DECEL_FRAC:  prdata = {15'd0, decel_fraction};
      default:                     prdata = 32'd0;
    endcase
  end

  // sequencer: owns the handshakes and the output beat's valid
  tmplan_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // datapath: plan state, divider, integration, output register
  tmplan_dp #(
    .PFB (POSITION_FRAC_BITS),
    .DW  (DURATION_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (dp_cmd),
    .stat              (dp_stat),
    .tick_period_ms    (tick_period_ms),
    .accel_fraction    (accel_fraction),
    .decel_fraction    (decel_fraction),
    .command           (item.command),
    .measured_position (item.measured_position),
    .plan_target       (item.plan_target),
    .plan_duration_ms  (item.plan_duration_ms),
    .setpoint          (result.setpoint),
    .phase             (result.phase),
    .plan_pending      (result.plan_pending)
  );
endmodule

// ===== hdl/tmplan_chk.sv =====
// Port-level checks for the motion planner, bound to the top level.
// Depends on trapezoidal_motion_planner.
module tmplan_chk (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] setpoint,
  input logic [1:0]  phase,
  input logic        plan_pending
);
  // nothing left in the output register after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // one item in flight: an accepted beat closes the input
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("second item taken while one is in work");

  // a new result only follows work, never a ready input
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!item_ready))
    else $error("result appeared without work");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(setpoint) &&
      $stable(phase) && $stable(plan_pending))
    else $error("stalled result changed");
endmodule

bind trapezoidal_motion_planner tmplan_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .setpoint     (result.setpoint),
  .phase        (result.phase),
  .plan_pending (result.plan_pending)
);

// ===== bench/tmplan_checker.sv =====
// Checker for the trapezoidal motion planner: watches both channels and the
// APB port, predicts every result beat and compares it. Needs tmplan_pkg and the two
// channel interfaces.
module tmplan_checker (
  input  logic         clk,
  input  logic         rst,
  tmplan_in_if         item,
  tmplan_out_if        result,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         pready,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output int           fail_count,
  output int           outstanding,
  output int           result_count
);
  typedef struct {
    logic signed [31:0]   setpoint;
    tmplan_pkg::phase_t   phase;
    logic                 plan_pending;
  } setpoint_beat_t;

  localparam longint VEL_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint VEL_LO = -VEL_HI - 1;

  setpoint_beat_t setpoint_q[$];

  // register copies
  longint dt_ms, af_reg, df_reg;
  // planner state copy
  tmplan_pkg::phase_t  mphase;
  logic    pend;
  longint  pend_target, pend_dur;
  longint  a_cnt, c_cnt, d_cnt, ph_cnt;
  longint  peak_v, acc_r, dec_r, last_v, last_sp;

  function automatic longint sat_vel(longint v);
    if (v > VEL_HI) return VEL_HI;
    if (v < VEL_LO) return VEL_LO;
    return v;
  endfunction

  function automatic longint sat_pos(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint floor_ticks(longint frac, longint dur, longint dt);
    return ((frac * dur) / (dt <<< 16)) & 64'hFFFF;
  endfunction

  function automatic longint clamp_frac(longint f);
    return (f > 65536) ? 65536 : f;
  endfunction

  // step the phase counter; roll over to the next phase at the limit
  task automatic bump(longint lim, tmplan_pkg::phase_t nxt);
    ph_cnt = (ph_cnt + 1) & 64'hFFFF;
    if (ph_cnt >= lim) begin
      mphase = nxt;
      ph_cnt = 0;
    end
  endtask

  task automatic motion_tick(longint pos, output longint sp);
    longint v, af, df, cf, dp, h;
    bit ok;
    v = 0;
    if (mphase == tmplan_pkg::PH_IDLE) begin
      if (!pend) begin
        sp = pos;
        return;
      end
      pend = 1'b0;
      af = clamp_frac(af_reg);
      df = clamp_frac(df_reg);
      ok = !(dt_ms == 0 || pend_dur <= dt_ms);
      if (ok) begin
        cf = (af + df >= 65536) ? 0 : 65536 - af - df;
        a_cnt = floor_ticks(af, pend_dur, dt_ms);
        d_cnt = floor_ticks(df, pend_dur, dt_ms);
        c_cnt = floor_ticks(cf, pend_dur, dt_ms);
        ok = (a_cnt != 0 && d_cnt != 0);
      end
      if (!ok) begin
        sp = last_sp;
        return;
      end
      dp = pend_target - pos;
      h = a_cnt + d_cnt + 2 * c_cnt;
      peak_v = sat_vel((dp * (64'sd1 <<< 17)) / h);
      acc_r = sat_vel(peak_v / a_cnt);
      dec_r = sat_vel(-(peak_v / d_cnt));
      last_v = 0;
      last_sp = pos;
      ph_cnt = 0;
      mphase = tmplan_pkg::PH_ACCEL;
    end
    case (mphase)
      tmplan_pkg::PH_ACCEL: begin
        v = sat_vel(last_v + acc_r);
        bump(a_cnt, tmplan_pkg::PH_CONST);
      end
      tmplan_pkg::PH_CONST: begin
        v = peak_v;
        bump(c_cnt, tmplan_pkg::PH_DECEL);
      end
      tmplan_pkg::PH_DECEL: begin
        v = sat_vel(last_v + dec_r);
        bump(d_cnt, tmplan_pkg::PH_IDLE);
      end
      default: ;
    endcase
    // halves round up: floor((v + 2^15) / 2^16)
    last_sp = sat_pos(last_sp + ((v + 64'sd32768) >>> 16));
    last_v = v;
    sp = last_sp;
  endtask

  task automatic predict_beat();
    setpoint_beat_t e;
    longint sp;
    sp = last_sp;
    case (tmplan_pkg::cmd_code_t'(item.command))
      tmplan_pkg::CMD_TICK: motion_tick(longint'(item.measured_position), sp);
      tmplan_pkg::CMD_QUEUE, tmplan_pkg::CMD_FORCE: begin
        pend_target = longint'(item.plan_target);
        pend_dur = longint'({1'b0, item.plan_duration_ms});
        pend = 1'b1;
        if (item.command == tmplan_pkg::CMD_FORCE) mphase = tmplan_pkg::PH_IDLE;
      end
      default: begin
        mphase = tmplan_pkg::PH_IDLE;
        pend = 1'b0;
      end
    endcase
    e.setpoint = sp[31:0];
    e.phase = mphase;
    e.plan_pending = pend;
    setpoint_q.push_back(e);
  endtask

  always @(posedge clk) begin
    setpoint_beat_t e;
    if (rst) begin
      dt_ms = 10; af_reg = 16384; df_reg = 16384;
      mphase = tmplan_pkg::PH_IDLE; pend = 1'b0; pend_target = 0; pend_dur = 0;
      a_cnt = 0; c_cnt = 0; d_cnt = 0; ph_cnt = 0;
      peak_v = 0; acc_r = 0; dec_r = 0; last_v = 0; last_sp = 0;
      setpoint_q.delete();
      fail_count = 0;
      result_count = 0;
      outstanding = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          tmplan_pkg::REG_TICK_PERIOD: dt_ms = pwdata[7:0];
          tmplan_pkg::REG_ACCEL_FRAC:  af_reg = pwdata[16:0];
          tmplan_pkg::REG_DECEL_FRAC:  df_reg = pwdata[16:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        result_count++;
        if (setpoint_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat setpoint %0d", $time, result.setpoint);
        end else begin
          e = setpoint_q.pop_front();
          if (result.setpoint !== e.setpoint) begin
            fail_count++;
            $display("%0t: setpoint expected %0d actual %0d", $time, e.setpoint,
                     result.setpoint);
          end
          if (result.phase !== e.phase) begin
            fail_count++;
            $display("%0t: phase expected %0d actual %0d", $time, e.phase, result.phase);
          end
          if (result.plan_pending !== e.plan_pending) begin
            fail_count++;
            $display("%0t: plan_pending expected %0b actual %0b", $time, e.plan_pending,
                     result.plan_pending);
          end
        end
      end
      if (item.valid && item.ready) predict_beat();
      outstanding = setpoint_q.size();
    end
  end
endmodule

// ===== bench/tb.sv =====
// Testbench top for the trapezoidal motion planner: clock, reset, APB writes,
// item stimulus and verdict. Needs tmplan_pkg, both channel interfaces and tmplan_checker.
module tb;
  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, outstanding, result_count;
  int          sent, idle_cycles, plans_sent;
  bit          quiet;      // no idling on either side while set
  longint      cur_dt;     // tb's view of tick period, for sizing plans
  logic signed [31:0] base_pos;

  tmplan_in_if  item ();
  tmplan_out_if result ();

  trapezoidal_motion_planner DUT (
    .clk(clk), .rst(rst), .item(item), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tmplan_checker chk (
    .clk(clk), .rst(rst), .item(item), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .outstanding(outstanding), .result_count(result_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure: ready is dropped at random, with a chance of about 23 percent
  always @(negedge clk) begin
    result.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 23);
  end

  // Watchdog: any accepted beat or APB access resets the count. The slowest
  // item is a plan start plus output stalls; the other long pause is the drain
  // before a register write.
  always @(posedge clk) begin
    if (rst || (item.valid && item.ready) || (result.valid && result.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 6000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // One beat on the input channel; valid stays high into the next beat unless that one idles first.
  task automatic send(tmplan_pkg::cmd_code_t cmd, logic [31:0] mp, logic [31:0] tgt,
                      logic [15:0] dur);
    while (!quiet && $urandom_range(99) < 23) begin
      item.valid <= 1'b0;
      @(negedge clk);
    end
    item.valid <= 1'b1;
    item.command <= cmd;
    item.measured_position <= mp;
    item.plan_target <= tgt;
    item.plan_duration_ms <= dur;
    do @(posedge clk); while (!item.ready);
    sent++;
    if (cmd == tmplan_pkg::CMD_QUEUE || cmd == tmplan_pkg::CMD_FORCE) plans_sent++;
    @(negedge clk);
  endtask

  // APB write: setup then access; written at the access edge
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // wait for the pipe to drain, then let any trailing plan-start work finish
  task automatic drain();
    item.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic set_config(logic [7:0] dt, logic [16:0] af, logic [16:0] df);
    drain();
    reg_write(tmplan_pkg::REG_TICK_PERIOD, {24'd0, dt});
    reg_write(tmplan_pkg::REG_ACCEL_FRAC, {15'd0, af});
    reg_write(tmplan_pkg::REG_DECEL_FRAC, {15'd0, df});
    cur_dt = dt;
  endtask

  // Random beat: mostly ticks, plans sized to up to 60 tick periods with the
  // target near the measured base, and some clears and full-range noise.
  task automatic random_beat();
    int sel;
    logic [31:0] mp, tgt;
    logic [15:0] dur;
    longint k;
    sel = $urandom_range(99);
    mp = ($urandom_range(9) == 0) ? $urandom : base_pos + ($urandom & 32'h000F_FFFF)
         - 32'h0008_0000;
    if ($urandom_range(7) == 0) tgt = $urandom;
    else tgt = base_pos + ($urandom & 32'h03FF_FFFF) - 32'h0200_0000;
    k = (cur_dt == 0 ? 10 : cur_dt) * $urandom_range(1, 60);
    dur = ($urandom_range(9) == 0) ? 16'($urandom) : 16'(k > 65535 ? 65535 : k);
    if (sel < 70)      send(tmplan_pkg::CMD_TICK, mp, $urandom, 16'($urandom));
    else if (sel < 85) send(tmplan_pkg::CMD_QUEUE, $urandom, tgt, dur);
    else if (sel < 93) send(tmplan_pkg::CMD_FORCE, $urandom, tgt, dur);
    else               send(tmplan_pkg::CMD_CLEAR, $urandom, $urandom, 16'($urandom));
    if ($urandom_range(49) == 0) base_pos = $urandom;
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    item.valid = 1'b0; item.command = tmplan_pkg::CMD_TICK; item.measured_position = '0;
    item.plan_target = '0; item.plan_duration_ms = '0;
    result.ready = 1'b0;
    quiet = 1'b0; cur_dt = 10; base_pos = 32'h0001_0000;
    sent = 0; plans_sent = 0; idle_cycles = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: idle echo at the extremes, invalid timings, saturating plan
    send(tmplan_pkg::CMD_TICK, 32'h7FFF_FFFF, '0, '0);
    send(tmplan_pkg::CMD_TICK, 32'h8000_0000, '0, '0);
    send(tmplan_pkg::CMD_QUEUE, '0, 32'h7FFF_FFFF, 16'd0);      // zero duration
    send(tmplan_pkg::CMD_TICK, 32'h1234_5678, '0, '0);
    send(tmplan_pkg::CMD_QUEUE, '0, 32'h0010_0000, 16'd10);     // one tick period exactly
    send(tmplan_pkg::CMD_TICK, 32'd0, '0, '0);
    send(tmplan_pkg::CMD_QUEUE, '0, 32'h0010_0000, 16'd30);     // accel count floors to zero
    send(tmplan_pkg::CMD_TICK, 32'd0, '0, '0);
    send(tmplan_pkg::CMD_QUEUE, '0, 32'h7FFF_FFFF, 16'd80);     // a=2 c=4 d=2, saturates
    repeat (10) send(tmplan_pkg::CMD_TICK, 32'h8000_0000, '0, '0);
    send(tmplan_pkg::CMD_FORCE, '0, 32'h8000_0000, 16'hFFFF);
    send(tmplan_pkg::CMD_TICK, 32'h7FFF_FFFF, '0, '0);
    send(tmplan_pkg::CMD_TICK, 32'h0, '0, '0);
    send(tmplan_pkg::CMD_CLEAR, '1, '1, '1);
    send(tmplan_pkg::CMD_TICK, 32'h0000_8000, '0, '0);

    // register settings, extremes among them; one phase runs with no idling
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config(8'd10, 17'd16384, 17'd16384);
        1: set_config(8'd1, 17'd6000, 17'd9000);
        2: set_config(8'd255, 17'h1FFFF, 17'h1FFFF);   // fractions clamp to one
        3: set_config(8'd0, 17'd20000, 17'd20000);     // every plan invalid
        4: set_config(8'd3, 17'd65536, 17'd0);
        default: set_config(8'd7, 17'd40000, 17'd10000);
      endcase
      quiet = (p == 4);
      repeat (125) random_beat();
    end
    quiet = 1'b0;

    drain();
    $display("tb: %0d beats sent (%0d plans), %0d results checked over six register settings",
             sent, plans_sent, result_count);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
